[hw/rtl/hsct_pkg.sv]
package hsct_pkg;

   localparam int POS_W   = 18;
   localparam int VEL_W   = 20;
   localparam int SIG_W   = 17;
   localparam int TIME_W  = 32;
   localparam int SIG_RST = 6554;
   localparam int FRAC_BITS_DEF = 16;

   localparam int REQ_DATA_W = 232;
   localparam int R_W     = POS_W + 1;
   localparam int V_W     = VEL_W + 1;
   localparam int RV_W    = R_W + V_W;
   localparam int RR_P_W  = 2 * R_W;
   localparam int VV_P_W  = 2 * V_W;
   localparam int B_W     = 41;
   localparam int MB_W    = 40;
   localparam int RR_W    = 38;
   localparam int VV_W    = 42;
   localparam int SS_W    = 2 * SIG_W;
   localparam int D_W     = RR_W + 1;
   localparam int AD_W    = RR_W;
   localparam int SPLIT   = 21;
   localparam int PP_W    = 2 * SPLIT;
   localparam int DISC_W  = 82;
   localparam int ROOT_W  = DISC_W / 2;
   localparam int REM_W   = ROOT_W + 1;

   typedef struct packed {
      logic [2:0][POS_W-1:0] a_pos;
      logic [2:0][POS_W-1:0] b_pos;
      logic [2:0][VEL_W-1:0] a_vel;
      logic [2:0][VEL_W-1:0] b_vel;
   } pair_type;

   typedef struct packed {
      logic              collide;
      logic [MB_W-1:0]   mb;
      logic [VV_W-1:0]   vv;
      logic [DISC_W-1:0] disc;
   } front_out_type;

   typedef struct packed {
      logic              collide;
      logic [MB_W-1:0]   mb;
      logic [VV_W-1:0]   vv;
      logic [ROOT_W-1:0] root;
   } sqrt_out_type;

   typedef struct packed {
      logic              collide;
      logic              zero;
      logic              sat;
      logic [TIME_W-1:0] q;
   } div_out_type;

endpackage

[hw/rtl/hard_sphere_collision_time.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  req_tdata: positions and velocities of a pair
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata: time_to_contact, rsp_tuser: will_collide
// csr       in         csr_valid/csr_ready    csr_data: contact_distance
//
// One pair is taken every cycle while req_tready is high. A req transaction
// passes seven arithmetic stages, a square root with one root bit per stage,
// two setup stages plus one quotient bit per stage, and the output register.
// Reset (synchronous) empties the pipeline and restores contact_distance to
// 6554. A stall on rsp freezes every stage at once; req_tready drops only
// while a result sits unaccepted in the output register.
module hard_sphere_collision_time
   import hsct_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // a_pos_x, a_pos_y, a_pos_z, b_pos_x, b_pos_y, b_pos_z (18 b each),
   // a_vel_x, a_vel_y, a_vel_z, b_vel_x, b_vel_y, b_vel_z (20 b each), 4 b zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // time_to_contact (32 b)
   output logic [TIME_W-1:0]      rsp_tdata,
   // will_collide (1 b)
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   // contact_distance (17 b)
   input  logic [SIG_W-1:0]       csr_data
);

   logic              adv;
   logic [SIG_W-1:0]  sigma_ff;
   pair_type          pair;
   logic              fr_valid, sq_valid, dv_valid;
   front_out_type     fr_data;
   sqrt_out_type      sq_data;
   div_out_type       dv_data;
   logic              rsp_valid_ff;
   logic              col_ff;
   logic [TIME_W-1:0] time_ff;
   logic [TIME_W-1:0] time_in;

   // advance the whole pipeline unless the output register is held
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // unpack the request transaction, first field in the low bits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pair.a_pos[i] = req_tdata[i*POS_W +: POS_W];
         pair.b_pos[i] = req_tdata[(i+3)*POS_W +: POS_W];
         pair.a_vel[i] = req_tdata[6*POS_W + i*VEL_W +: VEL_W];
         pair.b_vel[i] = req_tdata[6*POS_W + (i+3)*VEL_W +: VEL_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIG_W'(SIG_RST);
      end else if (csr_valid) begin
         sigma_ff <= csr_data;
      end
   end

   hsct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_tvalid),
      .in_pair   (pair),
      .sigma     (sigma_ff),
      .out_valid (fr_valid),
      .out_data  (fr_data)
   );

   hsct_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (fr_valid),
      .in_data   (fr_data),
      .out_valid (sq_valid),
      .out_data  (sq_data)
   );

   hsct_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_data   (sq_data),
      .out_valid (dv_valid),
      .out_data  (dv_data)
   );

   // no collision and too-late contact both read as all ones;
   // overlap clamps to zero
   always_comb begin
      priority if (!dv_data.collide) begin
         time_in = '1;
      end else if (dv_data.zero) begin
         time_in = '0;
      end else if (dv_data.sat) begin
         time_in = '1;
      end else begin
         time_in = dv_data.q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         col_ff  <= dv_data.collide;
         time_ff <= time_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = time_ff;
   assign rsp_tuser  = col_ff;

endmodule

[hw/rtl/hsct_front.sv]
module hsct_front
   import hsct_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  pair_type            in_pair,
   input  logic [SIG_W-1:0]    sigma,
   output logic                out_valid,
   output front_out_type       out_data
);

   logic [6:0] vld_ff;

   // stage 1: differences
   logic signed [R_W-1:0] r_ff [3];
   logic signed [V_W-1:0] v_ff [3];
   logic [SS_W-1:0]       ss_ff;
   // stage 2: products
   logic signed [RV_W-1:0]   rv_ff [3];
   logic signed [RR_P_W-1:0] rr_p_ff [3];
   logic signed [VV_P_W-1:0] vv_p_ff [3];
   // stage 3: dot products
   logic signed [B_W-1:0] b_ff;
   logic [RR_W-1:0]       rr_ff;
   logic [VV_W-1:0]       vv3_ff;
   // stage 4: magnitudes
   logic                  bneg_ff;
   logic [MB_W-1:0]       mb4_ff;
   logic                  dneg4_ff;
   logic [AD_W-1:0]       ad_ff;
   logic [VV_W-1:0]       vv4_ff;
   // stage 5: partial products
   logic [PP_W-1:0]       bhh_ff, bhl_ff, bll_ff;
   logic [PP_W-1:0]       phh_ff, phl_ff, plh_ff, pll_ff;
   logic                  bneg5_ff, dneg5_ff;
   logic [MB_W-1:0]       mb5_ff;
   logic [VV_W-1:0]       vv5_ff;
   // stage 6: full products
   logic [DISC_W-1:0]     bb_ff, p_ff;
   logic                  bneg6_ff, dneg6_ff;
   logic [MB_W-1:0]       mb6_ff;
   logic [VV_W-1:0]       vv6_ff;
   // stage 7: discriminant
   front_out_type         out_ff;

   logic signed [R_W-1:0] r_in [3];
   logic signed [V_W-1:0] v_in [3];
   logic signed [B_W-1:0] b_in;
   logic [VV_W-1:0]       vv_in;
   logic signed [D_W-1:0] d_in;
   logic [DISC_W:0]       diff_in;
   logic [DISC_W-1:0]     bb_in, p_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_in[i] = $signed({1'b0, in_pair.a_pos[i]}) - $signed({1'b0, in_pair.b_pos[i]});
         v_in[i] = $signed({in_pair.a_vel[i][VEL_W-1], in_pair.a_vel[i]})
                 - $signed({in_pair.b_vel[i][VEL_W-1], in_pair.b_vel[i]});
      end
      b_in  = B_W'(rv_ff[0]) + B_W'(rv_ff[1]) + B_W'(rv_ff[2]);
      vv_in = VV_W'(vv_p_ff[0]) + VV_W'(vv_p_ff[1]) + VV_W'(vv_p_ff[2]);
      d_in  = $signed({1'b0, rr_ff}) - $signed(D_W'(ss_ff));
      bb_in = (DISC_W'(bhh_ff) << (2 * SPLIT)) + (DISC_W'(bhl_ff) << (SPLIT + 1))
            + DISC_W'(bll_ff);
      p_in  = (DISC_W'(phh_ff) << (2 * SPLIT))
            + ((DISC_W'(phl_ff) + DISC_W'(plh_ff)) << SPLIT) + DISC_W'(pll_ff);
      diff_in = {1'b0, bb_ff} - {1'b0, p_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      ss_ff <= sigma * sigma;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            r_ff[i]    <= r_in[i];
            v_ff[i]    <= v_in[i];
            rv_ff[i]   <= r_ff[i] * v_ff[i];
            rr_p_ff[i] <= r_ff[i] * r_ff[i];
            vv_p_ff[i] <= v_ff[i] * v_ff[i];
         end
         b_ff   <= b_in;
         rr_ff  <= RR_W'(rr_p_ff[0]) + RR_W'(rr_p_ff[1]) + RR_W'(rr_p_ff[2]);
         vv3_ff <= vv_in;

         bneg_ff  <= b_ff[B_W-1];
         mb4_ff   <= b_ff[B_W-1] ? MB_W'(-b_ff) : MB_W'(b_ff);
         dneg4_ff <= d_in[D_W-1];
         ad_ff    <= d_in[D_W-1] ? AD_W'(-d_in) : AD_W'(d_in);
         vv4_ff   <= vv3_ff;

         bhh_ff   <= PP_W'(mb4_ff[MB_W-1:SPLIT]) * PP_W'(mb4_ff[MB_W-1:SPLIT]);
         bhl_ff   <= PP_W'(mb4_ff[MB_W-1:SPLIT]) * PP_W'(mb4_ff[SPLIT-1:0]);
         bll_ff   <= PP_W'(mb4_ff[SPLIT-1:0]) * PP_W'(mb4_ff[SPLIT-1:0]);
         phh_ff   <= PP_W'(vv4_ff[VV_W-1:SPLIT]) * PP_W'(ad_ff[AD_W-1:SPLIT]);
         phl_ff   <= PP_W'(vv4_ff[VV_W-1:SPLIT]) * PP_W'(ad_ff[SPLIT-1:0]);
         plh_ff   <= PP_W'(vv4_ff[SPLIT-1:0]) * PP_W'(ad_ff[AD_W-1:SPLIT]);
         pll_ff   <= PP_W'(vv4_ff[SPLIT-1:0]) * PP_W'(ad_ff[SPLIT-1:0]);
         bneg5_ff <= bneg_ff;
         dneg5_ff <= dneg4_ff;
         mb5_ff   <= mb4_ff;
         vv5_ff   <= vv4_ff;

         bb_ff    <= bb_in;
         p_ff     <= p_in;
         bneg6_ff <= bneg5_ff;
         dneg6_ff <= dneg5_ff;
         mb6_ff   <= mb5_ff;
         vv6_ff   <= vv5_ff;

         out_ff.collide <= bneg6_ff && (dneg6_ff || !diff_in[DISC_W]);
         out_ff.disc    <= dneg6_ff ? bb_ff + p_ff : diff_in[DISC_W-1:0];
         out_ff.mb      <= mb6_ff;
         out_ff.vv      <= vv6_ff;
      end
   end

   assign out_valid = vld_ff[6];
   assign out_data  = out_ff;

endmodule

[hw/rtl/hsct_sqrt.sv]
module hsct_sqrt
   import hsct_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  front_out_type  in_data,
   output logic           out_valid,
   output sqrt_out_type   out_data
);

   typedef struct packed {
      logic              collide;
      logic [MB_W-1:0]   mb;
      logic [VV_W-1:0]   vv;
      logic [DISC_W-1:0] d;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   logic [ROOT_W-1:0] vld_ff;
   sq_type            st_ff  [ROOT_W];
   sq_type            src    [ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_valid};
      end
   end

   assign src[0] = '{collide: in_data.collide, mb: in_data.mb, vv: in_data.vv,
                     d: in_data.disc, rem: '0, root: '0};

   // one root bit per stage, two radicand bits consumed each time
   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      if (g > 0) begin : g_link
         assign src[g] = st_ff[g-1];
      end

      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] sub;
      sq_type           nxt_in;

      always_comb begin
         rem_sh = {src[g].rem, src[g].d[DISC_W-1 -: 2]};
         trial  = (REM_W + 2)'({src[g].root, 2'b01});
         sub    = rem_sh - trial;
         nxt_in = src[g];
         nxt_in.d = src[g].d << 2;
         if (rem_sh >= trial) begin
            nxt_in.rem  = sub[REM_W-1:0];
            nxt_in.root = {src[g].root[ROOT_W-2:0], 1'b1};
         end else begin
            nxt_in.rem  = rem_sh[REM_W-1:0];
            nxt_in.root = {src[g].root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[g] <= nxt_in;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_data  = '{collide: st_ff[ROOT_W-1].collide, mb: st_ff[ROOT_W-1].mb,
                        vv: st_ff[ROOT_W-1].vv, root: st_ff[ROOT_W-1].root};

endmodule

[hw/rtl/hsct_div.sv]
module hsct_div
   import hsct_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  sqrt_out_type  in_data,
   output logic          out_valid,
   output div_out_type   out_data
);

   localparam int NW    = MB_W + FRAC_BITS;
   localparam int TOP_W = NW - TIME_W;
   localparam int NST   = TIME_W + 2;

   typedef struct packed {
      logic              collide;
      logic              zero;
      logic              sat;
      logic [VV_W-1:0]   vv;
      logic [VV_W-1:0]   rem;
      logic [TIME_W-1:0] low;
      logic [TIME_W-1:0] q;
   } dv_type;

   logic [NST-1:0] vld_ff;

   // numerator stage
   logic              col_p_ff, zero_p_ff;
   logic [MB_W-1:0]   n_ff;
   logic [VV_W-1:0]   vv_p_ff;
   // saturation check stage
   dv_type            head_ff;

   logic [NW-1:0]     num_in;
   logic [TOP_W-1:0]  top_in;
   logic              sat_in;

   always_comb begin
      num_in = {n_ff, {FRAC_BITS{1'b0}}};
      top_in = num_in[NW-1:TIME_W];
      sat_in = VV_W'(top_in) >= vv_p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_p_ff  <= in_data.collide;
         zero_p_ff <= in_data.root >= ROOT_W'(in_data.mb);
         n_ff      <= in_data.mb - in_data.root[MB_W-1:0];
         vv_p_ff   <= in_data.vv;

         head_ff.collide <= col_p_ff;
         head_ff.zero    <= zero_p_ff;
         head_ff.sat     <= sat_in;
         head_ff.vv      <= vv_p_ff;
         head_ff.rem     <= VV_W'(top_in);
         head_ff.low     <= num_in[TIME_W-1:0];
         head_ff.q       <= '0;
      end
   end

   dv_type st_ff [TIME_W];
   dv_type src   [TIME_W];

   assign src[0] = head_ff;

   // restoring division, one quotient bit per stage
   for (genvar g = 0; g < TIME_W; g++) begin : g_stage
      if (g > 0) begin : g_link
         assign src[g] = st_ff[g-1];
      end

      logic [VV_W:0] rem_sh;
      logic [VV_W:0] sub;
      dv_type        nxt_in;

      always_comb begin
         rem_sh = {src[g].rem, src[g].low[TIME_W-1]};
         sub    = rem_sh - {1'b0, src[g].vv};
         nxt_in = src[g];
         nxt_in.low = src[g].low << 1;
         if (rem_sh >= {1'b0, src[g].vv}) begin
            nxt_in.rem = sub[VV_W-1:0];
            nxt_in.q   = {src[g].q[TIME_W-2:0], 1'b1};
         end else begin
            nxt_in.rem = rem_sh[VV_W-1:0];
            nxt_in.q   = {src[g].q[TIME_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[g] <= nxt_in;
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_data  = '{collide: st_ff[TIME_W-1].collide, zero: st_ff[TIME_W-1].zero,
                        sat: st_ff[TIME_W-1].sat, q: st_ff[TIME_W-1].q};

endmodule

[hw/rtl/hsct_checker.sv]
module hsct_checker
   import hsct_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [TIME_W-1:0]      rsp_tdata,
   input  logic                   rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp transaction changed");

   // no collision reads as infinity
   a_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '1)
      else $error("miss without all-ones time");

   // never block input while the output side is empty
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

   // reset empties the pipeline
   a_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result right after reset");

endmodule

bind hard_sphere_collision_time hsct_checker u_hsct_checker (.*);
